/* rtl/assert_macros.svh */
// Assertion shorthands, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BFFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BFFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bffa_pkg.sv */
package bffa_pkg;

    localparam int MAP_BITS_DEF   = 1024;
    localparam int WORD_BITS_DEF  = 32;
    localparam int MAP_SIZE_RESET = 1024;
    localparam int CFG_W          = 11;
    localparam int POS_W          = 10;
    localparam int CNT_W          = 10;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOSPACE     = 2'd1,
        ST_BADRANGE    = 2'd2,
        ST_ALREADYFREE = 2'd3
    } status_t;

    // range walk flavor
    typedef enum logic [1:0] {
        MODE_CHECK,
        MODE_CLEAR,
        MODE_SET
    } mode_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_SEEK,
        S_SCAN_RD,
        S_SCAN_EV,
        S_RANGE_RD,
        S_RANGE_EV,
        S_RESP
    } state_t;

endpackage

/* rtl/bffa_channels.sv */
interface bffa_req_if;
    logic                            valid;
    logic                            ready;
    bffa_pkg::op_t                   op;
    logic [bffa_pkg::POS_W-1:0]      start_req;
    logic [bffa_pkg::CNT_W-1:0]      count;

    modport source (output valid, op, start_req, count, input ready);
    modport sink   (input valid, op, start_req, count, output ready);
endinterface

interface bffa_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bffa_pkg::POS_W-1:0]      position;
    bffa_pkg::status_t               status;

    modport source (output valid, position, status, input ready);
    modport sink   (input valid, position, status, output ready);
endinterface

/* rtl/bitmap_first_fit_allocator.sv */
// Bitmap first-fit allocator.
// req channel (valid/ready): op, start_req, count. rsp channel: position, status.
// cfg_wr_en/cfg_wr_data write map_size at any edge; write it only while idle.
// One request is handled at a time; req.ready is high only in the idle state.
// Alloc scans the map word by word (RAM read, then evaluate), then marks the
// run walking down over its words, again reading then evaluating each. Free
// first steps to the word of start_req, checks the spanned words, then clears
// them, with a RAM read and an evaluate step per word in each pass. Dispatch
// and response states come on top. All timing is set by the single RAM read
// port.
// Reset: map_size goes to 1024 and the map RAM is swept to zero, one word a
// cycle (MAP_WORDS words, 32 by default); no request is taken meanwhile.
// The result goes to an output register. If rsp is stalled, the block still
// takes and works on the next request; it then waits with that result until
// the register frees up.
module bitmap_first_fit_allocator #(
    parameter int MAP_BITS  = bffa_pkg::MAP_BITS_DEF,
    parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [bffa_pkg::CFG_W-1:0]  cfg_wr_data,
    bffa_req_if.sink                    req,
    bffa_rsp_if.source                  rsp
);

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW_RAW    = $clog2((MAP_WORDS + 1) * WORD_BITS) + 1;
    localparam int IW        = (IW_RAW > 12) ? IW_RAW : 12;

    // control
    bffa_pkg::state_t               state_reg, state_next;
    logic [AW-1:0]                  cur_reg, cur_next;
    logic                           out_valid_reg, out_valid_next;
    logic [bffa_pkg::CFG_W-1:0]     map_size_reg;

    // working payload
    bffa_pkg::op_t                  op_reg, op_next;
    bffa_pkg::mode_t                mode_reg, mode_next;
    logic [bffa_pkg::CNT_W-1:0]     need_reg, need_next;
    logic [IW-1:0]                  base_reg, base_next;
    logic [IW-1:0]                  run_reg, run_next;
    logic [IW-1:0]                  lo_reg, lo_next;
    logic [IW-1:0]                  hi_reg, hi_next;
    logic [AW-1:0]                  wcur_reg, wcur_next;     // first word of a free range
    logic [IW-1:0]                  wbase_reg, wbase_next;
    logic [bffa_pkg::POS_W-1:0]     res_pos_reg, res_pos_next;
    bffa_pkg::status_t              res_st_reg, res_st_next;
    logic [bffa_pkg::POS_W-1:0]     out_pos_reg, out_pos_next;
    bffa_pkg::status_t              out_st_reg, out_st_next;

    // live map size, clamped to the storage
    logic [IW-1:0]                  lsize;
    logic [IW-1:0]                  need_w;
    logic [IW-1:0]                  word_step;

    // RAM port
    logic                           ram_rd_en;
    logic                           ram_wr_en;
    logic [WORD_BITS-1:0]           ram_wr_data;
    logic [WORD_BITS-1:0]           ram_rd_data;

    // word unit
    logic                           u_hit;
    logic [IW-1:0]                  u_end;
    logic [IW-1:0]                  u_run;
    logic [WORD_BITS-1:0]           u_mask;

    assign lsize     = (IW'(map_size_reg) > IW'(MAP_BITS)) ? IW'(MAP_BITS)
                                                          : IW'(map_size_reg);
    assign need_w    = IW'(need_reg);
    assign word_step = IW'(WORD_BITS);

    bffa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (cur_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (cur_reg),
        .rd_data (ram_rd_data)
    );

    bffa_word_unit #(
        .WORD_BITS (WORD_BITS),
        .IW        (IW)
    ) u_word_unit (
        .word     (ram_rd_data),
        .base     (base_reg),
        .lim      (lsize - IW'(1)),
        .need     (need_w),
        .run      (run_reg),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .hit      (u_hit),
        .hit_end  (u_end),
        .run_next (u_run),
        .mask     (u_mask)
    );

    assign req.ready    = (state_reg == bffa_pkg::S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.position = out_pos_reg;
    assign rsp.status   = out_st_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        mode_next      = mode_reg;
        need_next      = need_reg;
        base_next      = base_reg;
        run_next       = run_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        wcur_next      = wcur_reg;
        wbase_next     = wbase_reg;
        res_pos_next   = res_pos_reg;
        res_st_next    = res_st_reg;
        out_pos_next   = out_pos_reg;
        out_st_next    = out_st_reg;
        ram_rd_en      = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_data    = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bffa_pkg::S_CLEAR:
            begin
                // post-reset sweep, zero one word per cycle
                ram_wr_en = 1'b1;
                if (cur_reg == AW'(MAP_WORDS - 1))
                begin
                    cur_next   = '0;
                    state_next = bffa_pkg::S_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + AW'(1);
                end
            end

            bffa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    lo_next    = IW'(req.start_req);
                    need_next  = req.count;
                    state_next = bffa_pkg::S_DISPATCH;
                end
            end

            bffa_pkg::S_DISPATCH:
            begin
                cur_next     = '0;
                base_next    = '0;
                run_next     = '0;
                res_pos_next = '0;
                if (need_reg == '0)
                begin
                    res_st_next = bffa_pkg::ST_BADRANGE;
                    state_next  = bffa_pkg::S_RESP;
                end
                else if (op_reg == bffa_pkg::OP_ALLOC)
                begin
                    if (need_w >= lsize)
                    begin
                        res_st_next = bffa_pkg::ST_NOSPACE;
                        state_next  = bffa_pkg::S_RESP;
                    end
                    else
                    begin
                        state_next = bffa_pkg::S_SCAN_RD;
                    end
                end
                else
                begin
                    if (lo_reg + need_w >= lsize)
                    begin
                        res_st_next = bffa_pkg::ST_BADRANGE;
                        state_next  = bffa_pkg::S_RESP;
                    end
                    else
                    begin
                        hi_next    = lo_reg + need_w - IW'(1);
                        mode_next  = bffa_pkg::MODE_CHECK;
                        state_next = bffa_pkg::S_SEEK;
                    end
                end
            end

            bffa_pkg::S_SEEK:
            begin
                // step up to the word holding start_req
                if (base_reg + word_step <= lo_reg)
                begin
                    cur_next  = cur_reg + AW'(1);
                    base_next = base_reg + word_step;
                end
                else
                begin
                    wcur_next  = cur_reg;
                    wbase_next = base_reg;
                    state_next = bffa_pkg::S_RANGE_RD;
                end
            end

            bffa_pkg::S_SCAN_RD:
            begin
                if (base_reg >= lsize - IW'(1))
                begin
                    res_st_next = bffa_pkg::ST_NOSPACE;
                    state_next  = bffa_pkg::S_RESP;
                end
                else
                begin
                    ram_rd_en  = 1'b1;
                    state_next = bffa_pkg::S_SCAN_EV;
                end
            end

            bffa_pkg::S_SCAN_EV:
            begin
                if (u_hit)
                begin
                    // run found: mark it walking down from this word
                    hi_next      = u_end;
                    lo_next      = u_end + IW'(1) - need_w;
                    res_pos_next = bffa_pkg::POS_W'(u_end + IW'(1) - need_w);
                    mode_next    = bffa_pkg::MODE_SET;
                    state_next   = bffa_pkg::S_RANGE_RD;
                end
                else
                begin
                    run_next   = u_run;
                    cur_next   = cur_reg + AW'(1);
                    base_next  = base_reg + word_step;
                    state_next = bffa_pkg::S_SCAN_RD;
                end
            end

            bffa_pkg::S_RANGE_RD:
            begin
                ram_rd_en  = 1'b1;
                state_next = bffa_pkg::S_RANGE_EV;
            end

            bffa_pkg::S_RANGE_EV:
            begin
                case (mode_reg)
                    bffa_pkg::MODE_CHECK:
                    begin
                        if ((~ram_rd_data & u_mask) != '0)
                        begin
                            res_st_next = bffa_pkg::ST_ALREADYFREE;
                            state_next  = bffa_pkg::S_RESP;
                        end
                        else if (base_reg + word_step > hi_reg)
                        begin
                            // all used: second pass clears
                            cur_next   = wcur_reg;
                            base_next  = wbase_reg;
                            mode_next  = bffa_pkg::MODE_CLEAR;
                            state_next = bffa_pkg::S_RANGE_RD;
                        end
                        else
                        begin
                            cur_next   = cur_reg + AW'(1);
                            base_next  = base_reg + word_step;
                            state_next = bffa_pkg::S_RANGE_RD;
                        end
                    end

                    bffa_pkg::MODE_CLEAR:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data & ~u_mask;
                        if (base_reg + word_step > hi_reg)
                        begin
                            res_st_next = bffa_pkg::ST_OK;
                            state_next  = bffa_pkg::S_RESP;
                        end
                        else
                        begin
                            cur_next   = cur_reg + AW'(1);
                            base_next  = base_reg + word_step;
                            state_next = bffa_pkg::S_RANGE_RD;
                        end
                    end

                    bffa_pkg::MODE_SET:
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = ram_rd_data | u_mask;
                        if (base_reg <= lo_reg)
                        begin
                            res_st_next = bffa_pkg::ST_OK;
                            state_next  = bffa_pkg::S_RESP;
                        end
                        else
                        begin
                            cur_next   = cur_reg - AW'(1);
                            base_next  = base_reg - word_step;
                            state_next = bffa_pkg::S_RANGE_RD;
                        end
                    end

                    default:
                    begin
                        state_next = bffa_pkg::S_RESP;
                    end
                endcase
            end

            bffa_pkg::S_RESP:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = res_pos_reg;
                    out_st_next    = res_st_reg;
                    state_next     = bffa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bffa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bffa_pkg::S_CLEAR;
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
            map_size_reg  <= bffa_pkg::CFG_W'(bffa_pkg::MAP_SIZE_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                map_size_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        mode_reg    <= mode_next;
        need_reg    <= need_next;
        base_reg    <= base_next;
        run_reg     <= run_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        wcur_reg    <= wcur_next;
        wbase_reg   <= wbase_next;
        res_pos_reg <= res_pos_next;
        res_st_reg  <= res_st_next;
        out_pos_reg <= out_pos_next;
        out_st_reg  <= out_st_next;
    end

endmodule

/* rtl/bffa_ram.sv */
module bffa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [WIDTH-1:0]      wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/bffa_word_unit.sv */
// Per-word evaluator: run search for alloc, bit mask for range walks.
module bffa_word_unit #(
    parameter int WORD_BITS = 32,
    parameter int IW        = 12
) (
    input  logic [WORD_BITS-1:0] word,
    input  logic [IW-1:0]        base,
    input  logic [IW-1:0]        lim,
    input  logic [IW-1:0]        need,
    input  logic [IW-1:0]        run,
    input  logic [IW-1:0]        lo,
    input  logic [IW-1:0]        hi,
    output logic                 hit,
    output logic [IW-1:0]        hit_end,
    output logic [IW-1:0]        run_next,
    output logic [WORD_BITS-1:0] mask
);

    logic [WORD_BITS-1:0] eu;
    logic [WORD_BITS-1:0] hit_vec;
    logic [IW-1:0]        len [WORD_BITS];
    logic [IW-1:0]        hit_off;

    // bits at or past the last usable bit count as used
    always_comb
    begin
        for (int k = 0; k < WORD_BITS; k++)
        begin
            eu[k]   = word[k] | ((base + IW'(k)) >= lim);
            mask[k] = ((base + IW'(k)) >= lo) && ((base + IW'(k)) <= hi);
        end
    end

    // free run length ending at each bit
    always_comb
    begin
        logic          found;
        logic [IW-1:0] lu;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            found = 1'b0;
            lu    = '0;
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (j <= b && eu[j])
                begin
                    found = 1'b1;
                    lu    = IW'(j);
                end
            end
            len[b]     = found ? (IW'(b) - lu) : (run + IW'(b) + IW'(1));
            hit_vec[b] = (len[b] >= need);
        end
    end

    always_comb
    begin
        hit_off = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (hit_vec[b])
            begin
                hit_off = IW'(b);
            end
        end
    end

    assign hit      = |hit_vec;
    assign hit_end  = base + hit_off;
    assign run_next = len[WORD_BITS-1];

endmodule

/* rtl/bffa_checker.sv */
`include "assert_macros.svh"

module bffa_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic [bffa_pkg::POS_W-1:0] rsp_position,
    input logic [1:0]                 rsp_status
);

    `BFFA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")
    `BFFA_ASSERT_NXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_position) && $stable(rsp_status), "rsp payload changed while stalled")
    `BFFA_ASSERT_IMP(a_fail_pos_zero, rsp_valid && rsp_status != bffa_pkg::ST_OK, rsp_position == '0, "nonzero position on failure")
    `BFFA_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready right after a transaction")

endmodule

bind bitmap_first_fit_allocator bffa_checker u_bffa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_position (rsp.position),
    .rsp_status   (rsp.status)
);
